// ===== src/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and letter tables for the integer to Roman numeral
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

   localparam int unsigned NUMBER_W = 12;
   localparam int unsigned LETTER_W = 8;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned THOU_W   = 2;
   localparam int unsigned STEP_W   = 2;
   localparam int unsigned PLACE_W  = 2;

   localparam logic [NUMBER_W-1:0] MAX_VALID = 12'd3999;

   localparam logic [LETTER_W-1:0] ASCII_I   = 8'h49;
   localparam logic [LETTER_W-1:0] ASCII_V   = 8'h56;
   localparam logic [LETTER_W-1:0] ASCII_X   = 8'h58;
   localparam logic [LETTER_W-1:0] ASCII_L   = 8'h4C;
   localparam logic [LETTER_W-1:0] ASCII_C   = 8'h43;
   localparam logic [LETTER_W-1:0] ASCII_D   = 8'h44;
   localparam logic [LETTER_W-1:0] ASCII_M   = 8'h4D;
   localparam logic [LETTER_W-1:0] ASCII_NUL = 8'h00;

   localparam logic [PLACE_W-1:0] PLACE_UNITS = 2'd0;
   localparam logic [PLACE_W-1:0] PLACE_TENS  = 2'd1;
   localparam logic [PLACE_W-1:0] PLACE_HUNDS = 2'd2;
   localparam logic [PLACE_W-1:0] PLACE_THOUS = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_EMIT,
      ST_FAULT
   } state_type;

   typedef enum logic [1:0] {
      KIND_ONE,
      KIND_FIVE,
      KIND_TEN
   } kind_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic split;
      logic emit;
      logic fault;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic in_range;
      logic last;
   } status_type;

   typedef struct packed {
      kind_type kind;
      logic     final_step;
   } step_info_type;

   // letter kind at a given step of one decimal digit, and whether it ends the digit
   function automatic step_info_type digit_step(input logic [DIGIT_W-1:0] digit,
                                                input logic [STEP_W-1:0]  step);
      step_info_type info;
      info.kind       = KIND_ONE;
      info.final_step = 1'b1;
      case (digit)
         4'd1: begin
            info.kind       = KIND_ONE;
            info.final_step = 1'b1;
         end
         4'd2: begin
            info.kind       = KIND_ONE;
            info.final_step = (step == 2'd1);
         end
         4'd3: begin
            info.kind       = KIND_ONE;
            info.final_step = (step == 2'd2);
         end
         4'd4: begin
            info.kind       = (step == 2'd0) ? KIND_ONE : KIND_FIVE;
            info.final_step = (step == 2'd1);
         end
         4'd5: begin
            info.kind       = KIND_FIVE;
            info.final_step = 1'b1;
         end
         4'd6: begin
            info.kind       = (step == 2'd0) ? KIND_FIVE : KIND_ONE;
            info.final_step = (step == 2'd1);
         end
         4'd7: begin
            info.kind       = (step == 2'd0) ? KIND_FIVE : KIND_ONE;
            info.final_step = (step == 2'd2);
         end
         4'd8: begin
            info.kind       = (step == 2'd0) ? KIND_FIVE : KIND_ONE;
            info.final_step = (step == 2'd3);
         end
         4'd9: begin
            info.kind       = (step == 2'd0) ? KIND_ONE : KIND_TEN;
            info.final_step = (step == 2'd1);
         end
         default: begin
            info.kind       = KIND_ONE;
            info.final_step = 1'b1;
         end
      endcase
      return info;
   endfunction

   function automatic logic [LETTER_W-1:0] place_letter(input logic [PLACE_W-1:0] place,
                                                        input kind_type           kind);
      logic [LETTER_W-1:0] ch;
      ch = ASCII_M;
      case (place)
         PLACE_UNITS: ch = (kind == KIND_ONE) ? ASCII_I : (kind == KIND_FIVE) ? ASCII_V : ASCII_X;
         PLACE_TENS:  ch = (kind == KIND_ONE) ? ASCII_X : (kind == KIND_FIVE) ? ASCII_L : ASCII_C;
         PLACE_HUNDS: ch = (kind == KIND_ONE) ? ASCII_C : (kind == KIND_FIVE) ? ASCII_D : ASCII_M;
         PLACE_THOUS: ch = ASCII_M;
         default:     ch = ASCII_M;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== src/i2r_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2r_ctrl
// Sequencer for the converter: load, decimal split, then one letter per
// cycle until the final letter is reported, or an error word if out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output i2r_pkg::cmd_type        cmd,
   input  wire i2r_pkg::status_type status
);

   i2r_pkg::state_type state_ff;
   i2r_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2r_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2r_pkg::ST_IDLE: begin
            if (start) state_in = i2r_pkg::ST_SPLIT;
         end
         i2r_pkg::ST_SPLIT: begin
            state_in = status.in_range ? i2r_pkg::ST_EMIT : i2r_pkg::ST_FAULT;
         end
         i2r_pkg::ST_EMIT: begin
            if (status.last) state_in = i2r_pkg::ST_IDLE;
         end
         i2r_pkg::ST_FAULT: begin
            state_in = i2r_pkg::ST_IDLE;
         end
         default: begin
            state_in = i2r_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         i2r_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         i2r_pkg::ST_SPLIT: begin
            cmd.split = 1'b1;
         end
         i2r_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         i2r_pkg::ST_FAULT: begin
            cmd.fault = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_start_to_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2r_pkg::ST_IDLE && start) |=> (state_ff == i2r_pkg::ST_SPLIT))
      else $error("accepted word did not enter split");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2r_pkg::ST_EMIT && status.last) |=> (state_ff == i2r_pkg::ST_IDLE))
      else $error("emission continued past final letter");

   a_fault_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2r_pkg::ST_FAULT) |=> (state_ff == i2r_pkg::ST_IDLE))
      else $error("error word not single");

endmodule

`default_nettype wire

// ===== src/i2r_datapath.sv =====
// ----------------------------------------------------------------------------
// i2r_datapath
// Input register, decimal split into digit registers, letter selection and
// the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire i2r_pkg::cmd_type               cmd,
   output i2r_pkg::status_type                 status,
   input  wire logic [i2r_pkg::NUMBER_W-1:0]   req_number,
   output logic                                rsp_strobe,
   output logic [i2r_pkg::LETTER_W-1:0]        rsp_letter,
   output logic                                rsp_out_of_range,
   output logic                                rsp_last_letter
);

   logic [i2r_pkg::NUMBER_W-1:0] number_ff;
   logic [i2r_pkg::THOU_W-1:0]   thou_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  hund_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  tens_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  unit_ff;
   logic [i2r_pkg::STEP_W-1:0]   step_ff;

   logic                         strobe_ff;
   logic [i2r_pkg::LETTER_W-1:0] letter_ff;
   logic                         oor_ff;
   logic                         last_ff;

   // decimal split
   logic [i2r_pkg::THOU_W-1:0]   thou_in;
   logic [9:0]                   rem_k;
   logic [15:0]                  hund_prod;
   logic [i2r_pkg::DIGIT_W-1:0]  hund_in;
   logic [6:0]                   rem_h;
   logic [14:0]                  tens_prod;
   logic [i2r_pkg::DIGIT_W-1:0]  tens_in;
   logic [i2r_pkg::DIGIT_W-1:0]  unit_in;

   // letter selection
   logic [i2r_pkg::PLACE_W-1:0]  place;
   logic [i2r_pkg::DIGIT_W-1:0]  cur_digit;
   logic                         lower_zero;
   i2r_pkg::step_info_type       info;

   always_comb begin
      if (number_ff >= 12'd3000) begin
         thou_in = 2'd3;
         rem_k   = 10'(number_ff - 12'd3000);
      end else if (number_ff >= 12'd2000) begin
         thou_in = 2'd2;
         rem_k   = 10'(number_ff - 12'd2000);
      end else if (number_ff >= 12'd1000) begin
         thou_in = 2'd1;
         rem_k   = 10'(number_ff - 12'd1000);
      end else begin
         thou_in = 2'd0;
         rem_k   = 10'(number_ff);
      end
      // floor(r/100) as r*41 >> 12, exact for r below 1000
      hund_prod = 16'(rem_k) * 16'd41;
      hund_in   = hund_prod[15:12];
      rem_h     = 7'(rem_k - 10'(hund_in) * 10'd100);
      // floor(r/10) as r*205 >> 11, exact for r below 100
      tens_prod = 15'(rem_h) * 15'd205;
      tens_in   = tens_prod[14:11];
      unit_in   = 4'(rem_h - 7'(tens_in) * 7'd10);
   end

   assign status.in_range = (number_ff != '0) && (number_ff <= i2r_pkg::MAX_VALID);

   // highest place that still has letters to give
   always_comb begin
      if (thou_ff != '0) begin
         place      = i2r_pkg::PLACE_THOUS;
         cur_digit  = 4'(thou_ff);
         lower_zero = (hund_ff == '0) && (tens_ff == '0) && (unit_ff == '0);
      end else if (hund_ff != '0) begin
         place      = i2r_pkg::PLACE_HUNDS;
         cur_digit  = hund_ff;
         lower_zero = (tens_ff == '0) && (unit_ff == '0);
      end else if (tens_ff != '0) begin
         place      = i2r_pkg::PLACE_TENS;
         cur_digit  = tens_ff;
         lower_zero = (unit_ff == '0);
      end else begin
         place      = i2r_pkg::PLACE_UNITS;
         cur_digit  = unit_ff;
         lower_zero = 1'b1;
      end
      info = i2r_pkg::digit_step(cur_digit, step_ff);
   end

   assign status.last = info.final_step && lower_zero;

   always_ff @(posedge clock) begin
      if (cmd.load) number_ff <= req_number;
      if (cmd.split) begin
         thou_ff <= thou_in;
         hund_ff <= hund_in;
         tens_ff <= tens_in;
         unit_ff <= unit_in;
         step_ff <= '0;
      end else if (cmd.emit) begin
         if (info.final_step) begin
            step_ff <= '0;
            case (place)
               i2r_pkg::PLACE_THOUS: thou_ff <= '0;
               i2r_pkg::PLACE_HUNDS: hund_ff <= '0;
               i2r_pkg::PLACE_TENS:  tens_ff <= '0;
               i2r_pkg::PLACE_UNITS: unit_ff <= '0;
               default:              unit_ff <= '0;
            endcase
         end else begin
            step_ff <= step_ff + 2'd1;
         end
      end
      if (cmd.emit) begin
         letter_ff <= i2r_pkg::place_letter(place, info.kind);
         oor_ff    <= 1'b0;
         last_ff   <= status.last;
      end else if (cmd.fault) begin
         letter_ff <= i2r_pkg::ASCII_NUL;
         oor_ff    <= 1'b1;
         last_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit | cmd.fault;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_letter       = letter_ff;
   assign rsp_out_of_range = oor_ff;
   assign rsp_last_letter  = last_ff;

endmodule

`default_nettype wire

// ===== src/integer_to_roman_numeral_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_top
// Converts a 12-bit binary number to its Roman numeral, one ASCII letter per
// result word, most significant letter first.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_number and raise start while busy is low; the word is
//   taken at that clock edge and busy goes high on the next cycle.
//   Output: each letter shows on rsp_letter for one cycle with rsp_strobe
//   high; rsp_last_letter marks the final letter of the numeral. Inputs of
//   0 or above 3999 give a single word with rsp_out_of_range and
//   rsp_last_letter set and rsp_letter zero.
//   Timing: the number is loaded, then split into decimal digits, then the
//   sequencer emits one letter per cycle; a numeral has 1 to 15 letters.
//   Busy drops as the final letter is registered, so the next start can be
//   taken in the cycle that letter is presented. The receiver cannot stall,
//   each result word is valid for exactly one cycle.
//   Reset: synchronous, active high; returns the sequencer to idle and
//   clears the strobe. No state is kept between items.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [i2r_pkg::NUMBER_W-1:0] req_number,
   output logic                              rsp_strobe,
   output logic [i2r_pkg::LETTER_W-1:0]      rsp_letter,
   output logic                              rsp_out_of_range,
   output logic                              rsp_last_letter
);

   i2r_pkg::cmd_type    cmd;
   i2r_pkg::status_type status;

   i2r_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   i2r_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_number       (req_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_letter       (rsp_letter),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_last_letter  (rsp_last_letter)
   );

endmodule

`default_nettype wire
